>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the point-in-polygon block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define WAPIP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define WAPIP_NEVER(label, clk, rst, cond, msg) \
   `WAPIP_ASSERT(label, clk, rst, !(cond), msg)

`endif

>>> hw/rtl/wapip_pkg.sv
// Types, constants and the arctangent table of the point-in-polygon block.
package wapip_pkg;

   // Store depth and CORDIC length.
   localparam int MAX_VERTICES = 64;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int ITER_W       = $clog2(TABLE_LEN);

   // Angle scales: 65536 units per turn outside, 2^24 inside the CORDIC.
   localparam int HALF_TURN       = 32768;
   localparam int FULL_TURN       = 65536;
   localparam int FINE_QUARTER    = 4194304;
   localparam int SUM_LIMIT       = 4194304;
   localparam int ROUND_BIAS      = 128;
   localparam int ROUND_SHIFT     = 8;
   localparam int VEC_SCALE_SHIFT = 14;

   // Widths of fields and internal values.
   localparam int REQ_W     = 2;
   localparam int COORD_W   = 16;
   localparam int SUM_OUT_W = 24;
   localparam int DELTA_W   = COORD_W + 1;
   localparam int ROT_W     = COORD_W + 2;
   localparam int CX_W      = 34;
   localparam int Z_W       = 26;
   localparam int ANG_W     = 17;
   localparam int VERTEX_W  = 2 * COORD_W;
   localparam int VADDR_W   = $clog2(MAX_VERTICES);
   localparam int VCNT_W    = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W     = (VADDR_W + ANG_W + 1 > SUM_OUT_W + 1) ?
                              (VADDR_W + ANG_W + 1) : (SUM_OUT_W + 1);

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

   // Input item.
   typedef struct packed {
      logic [REQ_W-1:0]          req_type;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
   } req_item_type;

   // Result item.
   typedef struct packed {
      logic                        inside_res;
      logic signed [SUM_OUT_W-1:0] angle_sum;
      logic                        list_full;
   } rsp_item_type;

   // Status of the shared CORDIC unit.
   typedef struct packed {
      logic busy;
      logic done;
   } cordic_sts_type;

   // atan(2^-i) at 2^24 units per turn, rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_step(input logic [ITER_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = 26'sd2097152;
         5'd1:    val = 26'sd1238021;
         5'd2:    val = 26'sd654136;
         5'd3:    val = 26'sd332050;
         5'd4:    val = 26'sd166669;
         5'd5:    val = 26'sd83416;
         5'd6:    val = 26'sd41718;
         5'd7:    val = 26'sd20860;
         5'd8:    val = 26'sd10430;
         5'd9:    val = 26'sd5215;
         5'd10:   val = 26'sd2608;
         5'd11:   val = 26'sd1304;
         5'd12:   val = 26'sd652;
         5'd13:   val = 26'sd326;
         5'd14:   val = 26'sd163;
         5'd15:   val = 26'sd81;
         5'd16:   val = 26'sd41;
         5'd17:   val = 26'sd20;
         5'd18:   val = 26'sd10;
         5'd19:   val = 26'sd5;
         5'd20:   val = 26'sd3;
         5'd21:   val = 26'sd1;
         5'd22:   val = 26'sd1;
         default: val = 26'sd0;
      endcase
      return val;
   endfunction

endpackage

>>> hw/rtl/wapip_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module wapip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/wapip_cordic.sv
// Iterative CORDIC unit that returns the direction angle of a vector.
`include "assert_macros.svh"

module wapip_cordic import wapip_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DELTA_W-1:0] vec_x,
   input  logic signed [DELTA_W-1:0] vec_y,
   output cordic_sts_type           sts,
   output logic signed [ANG_W-1:0]  angle
);

   localparam logic signed [Z_W-1:0] FINE_Q   = Z_W'(FINE_QUARTER);
   localparam logic signed [Z_W-1:0] BIAS     = Z_W'(ROUND_BIAS);
   localparam logic signed [Z_W-1:0] HALF_POS = Z_W'(HALF_TURN);
   localparam logic signed [Z_W-1:0] HALF_NEG = -Z_W'(HALF_TURN);

   logic                    running_ff, running_in;
   logic                    round_ff, round_in;
   logic                    done_ff, done_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic                    zero_ff, zero_in;
   logic signed [CX_W-1:0]  x_ff, x_in;
   logic signed [CX_W-1:0]  y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic signed [ANG_W-1:0] ang_ff, ang_in;

   logic signed [ROT_W-1:0] rot_x, rot_y;
   logic signed [Z_W-1:0]   rot_z;
   logic signed [CX_W-1:0]  shift_x, shift_y;
   logic signed [Z_W-1:0]   atan_val;
   logic signed [Z_W-1:0]   z_round;

   // Fold the left half-plane into the right one by a quarter turn.
   always_comb begin
      rot_x = ROT_W'(vec_x);
      rot_y = ROT_W'(vec_y);
      rot_z = '0;
      if (vec_x < 0) begin
         if (vec_y >= 0) begin
            rot_x = ROT_W'(vec_y);
            rot_y = -ROT_W'(vec_x);
            rot_z = FINE_Q;
         end else begin
            rot_x = -ROT_W'(vec_y);
            rot_y = ROT_W'(vec_x);
            rot_z = -FINE_Q;
         end
      end
   end

   // The shared shift and add datapath of one micro-rotation.
   assign shift_x  = x_ff >>> iter_ff;
   assign shift_y  = y_ff >>> iter_ff;
   assign atan_val = atan_step(iter_ff);

   // Round the fine angle to output units.
   assign z_round = (z_ff + BIAS) >>> ROUND_SHIFT;

   // Sequencer: load, iterate, round, then report done for one cycle.
   always_comb begin
      running_in = running_ff;
      round_in   = 1'b0;
      done_in    = 1'b0;
      iter_in    = iter_ff;
      zero_in    = zero_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      ang_in     = ang_ff;
      if (start) begin
         running_in = 1'b1;
         iter_in    = '0;
         zero_in    = (vec_x == 0) && (vec_y == 0);
         x_in       = CX_W'(rot_x) <<< VEC_SCALE_SHIFT;
         y_in       = CX_W'(rot_y) <<< VEC_SCALE_SHIFT;
         z_in       = rot_z;
      end else if (running_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + shift_y;
            y_in = y_ff - shift_x;
            z_in = z_ff + atan_val;
         end else begin
            x_in = x_ff - shift_y;
            y_in = y_ff + shift_x;
            z_in = z_ff - atan_val;
         end
         if (iter_ff == ITER_W'(CORDIC_ITERS - 1)) begin
            running_in = 1'b0;
            round_in   = 1'b1;
         end else begin
            iter_in = iter_ff + 1'b1;
         end
      end else if (round_ff) begin
         done_in = 1'b1;
         if (zero_ff) begin
            ang_in = '0;
         end else if (z_round > HALF_POS) begin
            ang_in = ANG_W'(HALF_POS);
         end else if (z_round < HALF_NEG) begin
            ang_in = ANG_W'(HALF_NEG);
         end else begin
            ang_in = ANG_W'(z_round);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         round_ff   <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         round_ff   <= round_in;
         done_ff    <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      zero_ff <= zero_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      ang_ff  <= ang_in;
   end

   assign sts.busy = running_ff | round_ff;
   assign sts.done = done_ff;
   assign angle    = ang_ff;

   `WAPIP_ASSERT(a_done_single, clock, reset, sts.done |=> !sts.done, "CORDIC done held for more than one cycle")
   `WAPIP_NEVER(a_iter_range, clock, reset, running_ff && (iter_ff >= ITER_W'(CORDIC_ITERS)), "CORDIC iteration count out of range")

endmodule

>>> hw/rtl/winding_angle_point_in_polygon_core.sv
// Top level of the winding-angle point-in-polygon block.
//
// Usage: items arrive on the req_ channel (valid/stall). A clear item empties
// the vertex list, an append item stores one vertex (dropped when the list is
// full), a query item asks whether its point lies inside the polygon. Every
// clear, append and query item gives one result item on the rsp_ channel;
// an item with the unused request code is taken and gives no result.
// Steps: a clear or append item goes from idle straight to the finish state,
// which loads its result into the output register once that register is
// free. A query walks the stored vertices in order; for each vertex the
// sequencer reads the store, loads the CORDIC, waits for the CORDIC
// micro-rotations on the single shared unit and its rounding step, and then
// takes the angle; closing the polygon and formatting the result follow. A
// query on an empty list goes straight to formatting the result.
// One item is worked on at a time; req_stall is high from the cycle after
// an item is taken until the result sits in the output register.
// The output register lets the block take the next item while a result is
// still stalled; a second result waits inside until the first is taken.
// Reset (synchronous, active high) empties the vertex list, drops any result
// not yet taken and returns the sequencer to idle.
`include "assert_macros.svh"

module winding_angle_point_in_polygon_core import wapip_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FETCH  = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_RUN    = 3'd3;
   localparam logic [2:0] ST_CLOSE  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam int STEP_W = ANG_W + 1;
   localparam logic signed [STEP_W-1:0]    STEP_HALF   = STEP_W'(HALF_TURN);
   localparam logic signed [STEP_W-1:0]    STEP_FULL   = STEP_W'(FULL_TURN);
   localparam logic signed [SUM_W-1:0]     SUM_HALF    = SUM_W'(HALF_TURN);
   localparam logic signed [SUM_W-1:0]     SUM_MAX     = SUM_W'(SUM_LIMIT);
   localparam logic signed [SUM_OUT_W-1:0] OUT_HALF    = SUM_OUT_W'(HALF_TURN);
   localparam logic [VCNT_W-1:0]           COUNT_LIMIT = VCNT_W'(MAX_VERTICES);

   logic [2:0]                state_ff, state_in;
   logic [VCNT_W-1:0]         count_ff, count_in;
   logic [VADDR_W-1:0]        idx_ff, idx_in;
   logic signed [COORD_W-1:0] px_ff, px_in;
   logic signed [COORD_W-1:0] py_ff, py_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [ANG_W-1:0]   first_ff, first_in;
   logic signed [ANG_W-1:0]   prev_ff, prev_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_item_type              rsp_data_ff, rsp_data_in;

   logic                      req_fire;
   logic                      out_free;
   logic                      list_has_room;
   logic                      last_vertex;
   logic                      ram_wr_en;
   logic [VERTEX_W-1:0]       ram_rd_data;
   logic signed [COORD_W-1:0] vert_x, vert_y;
   logic signed [DELTA_W-1:0] delta_x, delta_y;
   logic                      cordic_start;
   cordic_sts_type            cordic_sts;
   logic signed [ANG_W-1:0]   cordic_angle;
   logic signed [ANG_W-1:0]   step_a, step_b;
   logic signed [STEP_W-1:0]  step_diff, step_wrap;
   logic signed [SUM_W-1:0]   sum_next;
   logic                      sum_inside;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_fire      = req_valid && (state_ff == ST_IDLE);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign list_has_room = (count_ff < COUNT_LIMIT);
   assign last_vertex   = (VCNT_W'(idx_ff) == count_ff - VCNT_W'(1));
   assign ram_wr_en     = req_fire && (req_data.req_type == REQ_APPEND) && list_has_room;

   // Vertex store, x in the upper half of each word and y in the lower.
   wapip_ram #(
      .WIDTH (VERTEX_W),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[VADDR_W-1:0]),
      .wr_data ({req_data.coord_x, req_data.coord_y}),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // Vertex relative to the query point.
   assign vert_x  = ram_rd_data[VERTEX_W-1:COORD_W];
   assign vert_y  = ram_rd_data[COORD_W-1:0];
   assign delta_x = DELTA_W'(vert_x) - DELTA_W'(px_ff);
   assign delta_y = DELTA_W'(vert_y) - DELTA_W'(py_ff);

   assign cordic_start = (state_ff == ST_START);

   wapip_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .vec_x (delta_x),
      .vec_y (delta_y),
      .sts   (cordic_sts),
      .angle (cordic_angle)
   );

   // Angle step of one edge, wrapped into the half-turn range, and the new sum.
   always_comb begin
      step_a = cordic_angle;
      step_b = prev_ff;
      if (state_ff == ST_CLOSE) begin
         step_a = first_ff;
      end
      step_diff = STEP_W'(step_a) - STEP_W'(step_b);
      step_wrap = step_diff;
      if (step_diff > STEP_HALF) begin
         step_wrap = step_diff - STEP_FULL;
      end else if (step_diff < -STEP_HALF) begin
         step_wrap = step_diff + STEP_FULL;
      end
      sum_next = sum_ff + SUM_W'(step_wrap);
   end

   assign sum_inside = (sum_ff >= SUM_HALF) || (sum_ff <= -SUM_HALF);

   // Sequencer and result formatting.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      sum_in       = sum_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               px_in  = req_data.coord_x;
               py_in  = req_data.coord_y;
               sum_in = '0;
               idx_in = '0;
               case (req_data.req_type)
                  REQ_CLEAR: begin
                     count_in = '0;
                     state_in = ST_FINISH;
                  end
                  REQ_APPEND: begin
                     if (list_has_room) begin
                        count_in = count_ff + VCNT_W'(1);
                     end
                     state_in = ST_FINISH;
                  end
                  REQ_QUERY: begin
                     if (count_ff == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cordic_sts.done) begin
               prev_in = cordic_angle;
               if (idx_ff == '0) begin
                  first_in = cordic_angle;
               end else begin
                  sum_in = sum_next;
               end
               if (last_vertex) begin
                  state_in = ST_CLOSE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_CLOSE: begin
            sum_in   = sum_next;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.inside_res = sum_inside;
               rsp_data_in.list_full  = !list_has_room;
               if (sum_ff > SUM_MAX) begin
                  rsp_data_in.angle_sum = SUM_OUT_W'(SUM_MAX);
               end else if (sum_ff < -SUM_MAX) begin
                  rsp_data_in.angle_sum = SUM_OUT_W'(-SUM_MAX);
               end else begin
                  rsp_data_in.angle_sum = SUM_OUT_W'(sum_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      sum_ff      <= sum_in;
      first_ff    <= first_in;
      prev_ff     <= prev_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `WAPIP_ASSERT(a_count_bound, clock, reset,
      count_ff <= COUNT_LIMIT,
      "vertex count beyond store depth")
   `WAPIP_ASSERT(a_fetch_in_list, clock, reset,
      (state_ff == ST_FETCH) |-> (VCNT_W'(idx_ff) < count_ff),
      "vertex read beyond the list")
   `WAPIP_NEVER(a_cordic_overlap, clock, reset,
      cordic_start && cordic_sts.busy,
      "CORDIC started while busy")
   `WAPIP_ASSERT(a_outside_sum, clock, reset,
      (rsp_valid_ff && !rsp_data_ff.inside_res) |->
         ((rsp_data_ff.angle_sum < OUT_HALF) && (rsp_data_ff.angle_sum > -OUT_HALF)),
      "outside answer with a half-turn sum")

endmodule
